// ----- rtl/tlb_replacement_hit_counter_defines.svh -----
// ----------------------------------------------------------------------------
// TLB replacement hit counter: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TLB_REPLACEMENT_HIT_COUNTER_DEFINES_SVH
`define TLB_REPLACEMENT_HIT_COUNTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLBRHC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLBRHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tlbrhc_pkg.sv -----
// ----------------------------------------------------------------------------
// TLB replacement hit counter: shared package
// Field widths, register indexes, policy codes and the structs that travel
// along the cell row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlbrhc_pkg;

    localparam int VA_W   = 32;
    localparam int PN_W   = 22;
    localparam int OFF_W  = 5;
    localparam int CFG_W  = 5;
    localparam int CNT_W  = 7;  // holds an entry count up to the largest depth of 64
    localparam int IDX_W  = 6;  // slot index for up to 64 entries
    localparam int RANK_W = 6;  // recency rank up to 63
    localparam int HIT_W  = 32;

    localparam logic [OFF_W-1:0] OFF_MIN = 5'd10;
    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    localparam logic [1:0] CFG_PAGE_OFFSET = 2'd0;
    localparam logic [1:0] CFG_ACTIVE      = 2'd1;
    localparam logic [1:0] CFG_POLICY      = 2'd2;

    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_LIFO = 2'd1;
    localparam logic [1:0] POL_LRU  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    // Search results gathered as the token walks the cell row.
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [RANK_W-1:0] hit_rank;
        logic              lru_found;
        logic [IDX_W-1:0]  lru_idx;
        logic [RANK_W-1:0] lru_rank;
    } carry_t;

    // Update broadcast to every cell at the end of a search.
    typedef struct packed {
        logic              apply;
        logic              clear;
        logic              write;
        logic              older_all;
        logic [IDX_W-1:0]  slot;
        logic [RANK_W-1:0] limit;
    } upd_t;

endpackage

`default_nettype wire

// ----- rtl/tlbrhc_cell.sv -----
// ----------------------------------------------------------------------------
// TLB replacement hit counter: entry cell
// Holds one TLB entry, folds its compare and recency into the passing search
// token, and applies the broadcast fill and recency update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlbrhc_cell #(
    parameter int TLB_DEPTH  = 16,
    parameter int CELL_INDEX = 0
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire [tlbrhc_pkg::PN_W-1:0]  vpn,
    input  wire [tlbrhc_pkg::CNT_W-1:0] used,
    input  wire tlbrhc_pkg::carry_t    carry_in,
    output tlbrhc_pkg::carry_t         carry_out,
    input  wire tlbrhc_pkg::upd_t      upd
);

    localparam logic [tlbrhc_pkg::IDX_W-1:0]  MY_IDX   = tlbrhc_pkg::IDX_W'(CELL_INDEX);
    localparam logic [tlbrhc_pkg::CNT_W-1:0]  MY_CNT   = tlbrhc_pkg::CNT_W'(CELL_INDEX);
    localparam logic [tlbrhc_pkg::RANK_W-1:0] RANK_MAX = tlbrhc_pkg::RANK_W'(TLB_DEPTH - 1);

    logic [tlbrhc_pkg::PN_W-1:0]   page_reg;
    logic                          valid_reg;
    logic [tlbrhc_pkg::RANK_W-1:0] rank_reg;
    tlbrhc_pkg::carry_t            carry_reg;
    tlbrhc_pkg::carry_t            carry_next;
    logic                          active;
    logic                          match;
    logic                          is_slot;
    logic                          ages;

    assign active  = MY_CNT < used;
    assign match   = active && valid_reg && (page_reg == vpn);
    assign is_slot = upd.slot == MY_IDX;
    // Entries more recent than the touched one age; a fill ages them all.
    assign ages    = active && valid_reg && (rank_reg < RANK_MAX)
                     && (upd.older_all || (rank_reg < upd.limit));

    always_comb
    begin
        carry_next = carry_in;
        if (!carry_in.hit && match)
        begin
            carry_next.hit      = 1'b1;
            carry_next.hit_idx  = MY_IDX;
            carry_next.hit_rank = rank_reg;
        end
        // Strictly greater keeps the lowest index on a tie.
        if (active && valid_reg && (!carry_in.lru_found || (rank_reg > carry_in.lru_rank)))
        begin
            carry_next.lru_found = 1'b1;
            carry_next.lru_idx   = MY_IDX;
            carry_next.lru_rank  = rank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
        end
    end

    assign carry_out = carry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else if (upd.apply)
        begin
            if (upd.clear)
            begin
                valid_reg <= 1'b0;
                rank_reg  <= '0;
            end
            else if (is_slot)
            begin
                rank_reg <= '0;
                if (upd.write)
                begin
                    valid_reg <= 1'b1;
                end
            end
            else if (ages)
            begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.apply && !upd.clear && is_slot && upd.write)
        begin
            page_reg <= vpn;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tlb_replacement_hit_counter.sv -----
// ----------------------------------------------------------------------------
// TLB replacement hit counter: top level
// Fully associative TLB with FIFO, LIFO or least recently used replacement
// and a saturating hit count that clears after the last item of a run.
// ----------------------------------------------------------------------------
// One item at a time: busy stays high while the search token walks the row of
// TLB_DEPTH entry cells, one cell per cycle, and the update is applied as the
// token leaves the last cell; a new item is taken only once busy is low.
// Results cannot be stalled by the receiver; each is shown for one cycle.
// Reset clears the table, ranks, pointer and count and loads the register
// defaults (offset 12, 16 entries, FIFO).
`timescale 1ns / 1ps
`default_nettype none

module tlb_replacement_hit_counter #(
    parameter int TLB_DEPTH = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire [tlbrhc_pkg::VA_W-1:0]   virtual_address,
    input  wire                          last_access,
    output logic                         result_valid,
    output logic                         hit,
    output logic [tlbrhc_pkg::HIT_W-1:0] hit_total,
    output logic                         run_done,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [1:0]                    cfg_index,
    input  wire [tlbrhc_pkg::CFG_W-1:0]  cfg_data
);

`include "tlb_replacement_hit_counter_defines.svh"

    localparam int CNT_W = tlbrhc_pkg::CNT_W;
    localparam int IDX_W = tlbrhc_pkg::IDX_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TLB_DEPTH);

    // Configuration registers
    logic [tlbrhc_pkg::OFF_W-1:0] page_offset_bits_reg;
    logic [4:0]                   active_entries_reg;
    logic [1:0]                   replacement_policy_reg;

    tlbrhc_pkg::state_t state_reg;
    tlbrhc_pkg::state_t state_next;

    logic [tlbrhc_pkg::PN_W-1:0]  vpn_reg;
    logic [tlbrhc_pkg::PN_W-1:0]  vpn_next;
    logic [tlbrhc_pkg::OFF_W-1:0] off;
    logic                         last_reg;
    logic                         seed_valid_reg;
    logic [CNT_W-1:0]             ptr_reg;
    logic [CNT_W-1:0]             ptr_next;
    logic [tlbrhc_pkg::HIT_W-1:0] count_reg;
    logic [tlbrhc_pkg::HIT_W-1:0] count_inc;
    logic                         result_valid_reg;
    logic                         hit_reg;
    logic [tlbrhc_pkg::HIT_W-1:0] hit_total_reg;
    logic                         run_done_reg;

    logic [CNT_W-1:0]   act_ext;
    logic [CNT_W-1:0]   used;
    logic [CNT_W-1:0]   slot_cnt;
    logic               accept;
    logic               finish;
    tlbrhc_pkg::carry_t seed;
    tlbrhc_pkg::carry_t fin;
    tlbrhc_pkg::upd_t   upd;
    tlbrhc_pkg::carry_t link [TLB_DEPTH+1];

    assign cfg_ready = 1'b1;
    assign busy      = state_reg != tlbrhc_pkg::ST_IDLE;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_offset_bits_reg   <= 5'd12;
            active_entries_reg     <= 5'd16;
            replacement_policy_reg <= tlbrhc_pkg::POL_FIFO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tlbrhc_pkg::CFG_PAGE_OFFSET: page_offset_bits_reg   <= cfg_data;
                tlbrhc_pkg::CFG_ACTIVE:      active_entries_reg     <= cfg_data;
                tlbrhc_pkg::CFG_POLICY:      replacement_policy_reg <= cfg_data[1:0];
                default:                     ;
            endcase
        end
    end

    // Entry count in use, clamped to 1..TLB_DEPTH.
    assign act_ext = CNT_W'(active_entries_reg);
    always_comb
    begin
        if (act_ext == '0)
        begin
            used = CNT_W'(1);
        end
        else if (act_ext > DEPTH_CNT)
        begin
            used = DEPTH_CNT;
        end
        else
        begin
            used = act_ext;
        end
    end

    assign off      = (page_offset_bits_reg < tlbrhc_pkg::OFF_MIN) ? tlbrhc_pkg::OFF_MIN
                                                                   : page_offset_bits_reg;
    assign vpn_next = tlbrhc_pkg::PN_W'(virtual_address >> off);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vpn_reg  <= vpn_next;
            last_reg <= last_access;
        end
    end

    // The token enters the row in the cycle after the item is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_valid_reg <= 1'b0;
        end
        else
        begin
            seed_valid_reg <= accept;
        end
    end

    always_comb
    begin
        seed       = '0;
        seed.valid = seed_valid_reg;
    end

    assign link[0] = seed;

    genvar gi;
    generate
        for (gi = 0; gi < TLB_DEPTH; gi++)
        begin : g_cell
            tlbrhc_cell #(
                .TLB_DEPTH  (TLB_DEPTH),
                .CELL_INDEX (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .vpn       (vpn_reg),
                .used      (used),
                .carry_in  (link[gi]),
                .carry_out (link[gi+1]),
                .upd       (upd)
            );
        end
    endgenerate

    assign fin    = link[TLB_DEPTH];
    assign finish = (state_reg == tlbrhc_pkg::ST_SEARCH) && fin.valid;

    // Slot choice and pointer advance once the whole row has been searched.
    always_comb
    begin
        ptr_next = ptr_reg;
        slot_cnt = '0;
        if (fin.hit)
        begin
            slot_cnt = CNT_W'(fin.hit_idx);
        end
        else
        begin
            case (replacement_policy_reg)
                tlbrhc_pkg::POL_FIFO:
                begin
                    slot_cnt = (ptr_reg < used) ? ptr_reg : '0;
                    ptr_next = (slot_cnt + 1'b1 == used) ? '0 : slot_cnt + 1'b1;
                end
                tlbrhc_pkg::POL_LIFO:
                begin
                    slot_cnt = (ptr_reg < used) ? ptr_reg : used - 1'b1;
                    ptr_next = (slot_cnt + 1'b1 < used) ? slot_cnt + 1'b1 : used - 1'b1;
                end
                default:
                begin
                    // Least recently used; the unused code behaves the same.
                    if (ptr_reg < used)
                    begin
                        slot_cnt = ptr_reg;
                        ptr_next = ptr_reg + 1'b1;
                    end
                    else
                    begin
                        slot_cnt = fin.lru_found ? CNT_W'(fin.lru_idx) : '0;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        upd.apply     = finish;
        upd.clear     = last_reg;
        upd.write     = !fin.hit;
        upd.older_all = !fin.hit;
        upd.slot      = slot_cnt[IDX_W-1:0];
        upd.limit     = fin.hit_rank;
    end

    assign count_inc = (fin.hit && (count_reg != tlbrhc_pkg::HIT_MAX)) ? count_reg + 1'b1
                                                                       : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            count_reg <= '0;
        end
        else if (finish)
        begin
            if (last_reg)
            begin
                ptr_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                ptr_reg   <= ptr_next;
                count_reg <= count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tlbrhc_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= finish;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlbrhc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = tlbrhc_pkg::ST_SEARCH;
                end
            end
            tlbrhc_pkg::ST_SEARCH:
            begin
                if (fin.valid)
                begin
                    state_next = tlbrhc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlbrhc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            hit_reg       <= fin.hit;
            hit_total_reg <= count_inc;
            run_done_reg  <= last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign hit          = hit_reg;
    assign hit_total    = hit_total_reg;
    assign run_done     = run_done_reg;

    `TLBRHC_ASSERT_NEXT(a_accept_busy, accept, busy, "item taken but block not busy")
    `TLBRHC_ASSERT_SAME(a_result_idle, result_valid, !busy, "result shown while still busy")
    `TLBRHC_ASSERT_SAME(a_token_search, fin.valid, state_reg == tlbrhc_pkg::ST_SEARCH, "token outside search")
    `TLBRHC_ASSERT_SAME(a_hit_count, result_valid && hit, hit_total != '0, "hit with zero count")

endmodule

`default_nettype wire

// ----- verif/tlb_replacement_hit_counter_tb.sv -----
// ----------------------------------------------------------------------------
// TLB replacement hit counter: testbench
// Drives accesses through the start/busy port and programs the offset, entry
// count and policy through the register channel between phases. A
// scoreboard class keeps its own copy of the table, ranks, pointer and hit
// count, and checks every strobed result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlb_replacement_hit_counter_tb;

    localparam int VA_W  = tlbrhc_pkg::VA_W;
    localparam int PN_W  = tlbrhc_pkg::PN_W;
    localparam int OFF_W = tlbrhc_pkg::OFF_W;
    localparam int CFG_W = tlbrhc_pkg::CFG_W;
    localparam int HIT_W = tlbrhc_pkg::HIT_W;

    localparam int DEPTH       = 16;
    localparam int ITEM_TARGET = 1850;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic             hit;
        logic [HIT_W-1:0] total;
        logic             done;
    } lookup_t;

    class tlb_lookup_model;
        logic [OFF_W-1:0] offset_reg;
        logic [CFG_W-1:0] entries_reg;
        logic [1:0]       policy_reg;
        logic [PN_W-1:0]  page_no [DEPTH];
        bit               slot_used [DEPTH];
        int unsigned      age [DEPTH];
        int unsigned      fill_ptr;
        logic [HIT_W-1:0] hit_count;
        lookup_t          pending_lookups [$];
        int unsigned      mismatches;

        function new();
            offset_reg  = 5'd12;
            entries_reg = 5'd16;
            policy_reg  = tlbrhc_pkg::POL_FIFO;
            mismatches  = 0;
            clear_run();
        endfunction

        function void clear_run();
            for (int j = 0; j < DEPTH; j++)
            begin
                page_no[j]   = '0;
                slot_used[j] = 1'b0;
                age[j]       = 0;
            end
            fill_ptr  = 0;
            hit_count = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                tlbrhc_pkg::CFG_PAGE_OFFSET: offset_reg = data;
                tlbrhc_pkg::CFG_ACTIVE:      entries_reg = data;
                tlbrhc_pkg::CFG_POLICY:      policy_reg = data[1:0];
                default:                     ;
            endcase
        endfunction

        function int unsigned eff_offset();
            return (offset_reg < tlbrhc_pkg::OFF_MIN) ? tlbrhc_pkg::OFF_MIN : offset_reg;
        endfunction

        function int unsigned in_use();
            if (entries_reg == 0)
                return 1;
            if (entries_reg > DEPTH)
                return DEPTH;
            return entries_reg;
        endfunction

        function int unsigned pending();
            return pending_lookups.size();
        endfunction

        // The touched slot becomes most recent; a fresh fill ages everyone.
        function void touch(int unsigned e, int unsigned n, bit older_all);
            int unsigned limit;
            limit = age[e];
            for (int unsigned j = 0; j < n; j++)
            begin
                if (j != e && slot_used[j] && (older_all || age[j] < limit))
                begin
                    if (age[j] < DEPTH - 1)
                        age[j]++;
                end
            end
            age[e] = 0;
        endfunction

        function void note_access(logic [VA_W-1:0] va, logic is_last);
            logic [PN_W-1:0] pn;
            int unsigned     n;
            int unsigned     slot;
            bit              matched;
            bit              found;
            lookup_t         res;
            pn      = PN_W'(va >> eff_offset());
            n       = in_use();
            matched = 1'b0;
            slot    = 0;
            for (int unsigned j = 0; j < n; j++)
            begin
                if (!matched && slot_used[j] && page_no[j] == pn)
                begin
                    matched = 1'b1;
                    slot    = j;
                end
            end
            if (matched)
            begin
                if (hit_count != tlbrhc_pkg::HIT_MAX)
                    hit_count++;
                touch(slot, n, 1'b0);
            end
            else
            begin
                if (policy_reg == tlbrhc_pkg::POL_FIFO)
                begin
                    slot     = (fill_ptr < n) ? fill_ptr : 0;
                    fill_ptr = (slot + 1 == n) ? 0 : slot + 1;
                end
                else if (policy_reg == tlbrhc_pkg::POL_LIFO)
                begin
                    slot     = (fill_ptr < n) ? fill_ptr : n - 1;
                    fill_ptr = (slot + 1 < n) ? slot + 1 : n - 1;
                end
                else if (fill_ptr < n)
                begin
                    slot = fill_ptr;
                    fill_ptr++;
                end
                else
                begin
                    // Oldest valid entry wins, lowest index on a tie.
                    found = 1'b0;
                    slot  = 0;
                    for (int unsigned j = 0; j < n; j++)
                    begin
                        if (slot_used[j] && (!found || age[j] > age[slot]))
                        begin
                            slot  = j;
                            found = 1'b1;
                        end
                    end
                end
                page_no[slot]   = pn;
                slot_used[slot] = 1'b1;
                touch(slot, n, 1'b1);
            end
            res.hit   = matched;
            res.total = hit_count;
            res.done  = is_last;
            pending_lookups.push_back(res);
            if (is_last)
                clear_run();
        endfunction

        function void check_lookup(logic got_hit, logic [HIT_W-1:0] got_total, logic got_done);
            lookup_t want;
            if (pending_lookups.size() == 0)
            begin
                $error("result strobe with no access outstanding");
                mismatches++;
                return;
            end
            want = pending_lookups.pop_front();
            if (got_hit !== want.hit)
            begin
                $error("hit: expected %0d, got %0d", want.hit, got_hit);
                mismatches++;
            end
            if (got_total !== want.total)
            begin
                $error("hit_total: expected %0d, got %0d", want.total, got_total);
                mismatches++;
            end
            if (got_done !== want.done)
            begin
                $error("run_done: expected %0d, got %0d", want.done, got_done);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [VA_W-1:0]   virtual_address = '0;
    logic              last_access = 1'b0;
    logic              result_valid;
    logic              hit;
    logic [HIT_W-1:0]  hit_total;
    logic              run_done;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = tlbrhc_pkg::CFG_PAGE_OFFSET;
    logic [CFG_W-1:0]  cfg_data = '0;

    tlb_lookup_model lookups = new();
    int unsigned     sender_idle_pct = 0;
    int unsigned     cycle_count = 0;

    tlb_replacement_hit_counter #(
        .TLB_DEPTH(DEPTH)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .virtual_address (virtual_address),
        .last_access     (last_access),
        .result_valid    (result_valid),
        .hit             (hit),
        .hit_total       (hit_total),
        .run_done        (run_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            lookups.check_lookup(hit, hit_total, run_done);
    end

    // Leaves start high after the item is taken; the caller lowers it.
    task automatic send_item(input logic [VA_W-1:0] va, input logic is_last);
        bit offered;
        bit taken;
        virtual_address <= va;
        last_access     <= is_last;
        taken = 1'b0;
        while (!taken)
        begin
            offered = ($urandom_range(99) >= sender_idle_pct);
            start <= offered;
            @(posedge clk);
            if (offered && !busy)
            begin
                taken = 1'b1;
                lookups.note_access(va, is_last);
            end
        end
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        while (lookups.pending() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        lookups.set_reg(idx, data);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] off, input logic [CFG_W-1:0] ent,
                                input logic [1:0] pol);
        write_cfg(tlbrhc_pkg::CFG_PAGE_OFFSET, off);
        write_cfg(tlbrhc_pkg::CFG_ACTIVE, ent);
        write_cfg(tlbrhc_pkg::CFG_POLICY, 5'(pol));
        cfg_valid <= 1'b0;
    endtask

    // Builds an address on the given page under the current offset width.
    function automatic logic [VA_W-1:0] addr_for(input logic [PN_W-1:0] pn);
        logic [63:0] wide;
        int unsigned sh;
        sh   = lookups.eff_offset();
        wide = (64'(pn) << sh) | (64'($urandom) & ((64'd1 << sh) - 64'd1));
        return wide[VA_W-1:0];
    endfunction

    task automatic send_page(input logic [PN_W-1:0] pn, input logic is_last);
        send_item(addr_for(pn), is_last);
    endtask

    initial
    begin
        logic [PN_W-1:0]  page_pool [24];
        int unsigned      pool_size;
        int unsigned      phase_len;
        int unsigned      sent;
        int unsigned      sel;
        logic [CFG_W-1:0] off;
        logic [CFG_W-1:0] ent;
        logic [VA_W-1:0]  va;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers: all-zero and all-one addresses, then page hits.
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0FFF, 1'b0);
        send_item(32'hFFFF_F000, 1'b0);
        send_item(32'h1234_5678, 1'b1);

        // Offset below range, four entries, LIFO keeps replacing the last slot.
        wait_quiet();
        write_cfg(CFG_UNUSED, 5'h1F);
        program_regs(5'd0, 5'd4, tlbrhc_pkg::POL_LIFO);
        send_page(22'd1, 1'b0);
        send_page(22'd2, 1'b0);
        send_page(22'd3, 1'b0);
        send_page(22'd4, 1'b0);
        send_page(22'd5, 1'b0);
        send_page(22'd5, 1'b0);
        send_page(22'd1, 1'b1);

        // Widest offset, zero entries and the spare policy code.
        wait_quiet();
        program_regs(5'd31, 5'd0, CFG_UNUSED);
        send_page(22'd0, 1'b0);
        send_page(22'd1, 1'b0);
        send_page(22'd0, 1'b1);

        // Least recently used eviction on three entries.
        wait_quiet();
        program_regs(5'd12, 5'd3, tlbrhc_pkg::POL_LRU);
        send_page(22'd10, 1'b0);
        send_page(22'd11, 1'b0);
        send_page(22'd12, 1'b0);
        send_page(22'd10, 1'b0);
        send_page(22'd13, 1'b0);
        send_page(22'd11, 1'b1);

        // Shrinking the table then growing it past the depth leaves a duplicate.
        wait_quiet();
        program_regs(5'd12, 5'd4, tlbrhc_pkg::POL_FIFO);
        send_page(22'd20, 1'b0);
        send_page(22'd21, 1'b0);
        send_page(22'd22, 1'b0);
        wait_quiet();
        program_regs(5'd12, 5'd1, tlbrhc_pkg::POL_FIFO);
        send_page(22'd22, 1'b0);
        wait_quiet();
        program_regs(5'd12, 5'd31, tlbrhc_pkg::POL_FIFO);
        send_page(22'd22, 1'b1);

        sent = 0;
        for (int phase = 0; sent < ITEM_TARGET; phase++)
        begin
            wait_quiet();
            case (phase % 4)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 69;
                2: sender_idle_pct = 0;
                default: sender_idle_pct = 19;
            endcase
            sel = $urandom_range(5);
            case (sel)
                0: off = 5'd0;
                1: off = 5'd9;
                2: off = 5'd10;
                3: off = 5'd31;
                default: off = 5'($urandom_range(10, 20));
            endcase
            sel = $urandom_range(6);
            case (sel)
                0: ent = 5'd0;
                1: ent = 5'd1;
                2: ent = 5'd16;
                3: ent = 5'd31;
                default: ent = 5'($urandom_range(1, DEPTH));
            endcase
            program_regs(off, ent, 2'($urandom_range(3)));

            // A pool as large as the table in use or slightly larger gives both hits and evictions.
            pool_size = lookups.in_use() + $urandom_range(0, 4);
            for (int i = 0; i < pool_size; i++)
                page_pool[i] = PN_W'($urandom);
            phase_len = $urandom_range(30, 110);
            for (int k = 0; k < phase_len && sent < ITEM_TARGET; k++)
            begin
                if ($urandom_range(99) < 8)
                    va = $urandom;
                else
                    va = addr_for(page_pool[$urandom_range(pool_size - 1)]);
                send_item(va, ($urandom_range(59) == 0));
                sent++;
                if ($urandom_range(299) == 0)
                    wait_quiet();
            end
        end

        wait_quiet();
        if (lookups.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tlbrhc_pkg.sv
rtl/tlbrhc_cell.sv
rtl/tlb_replacement_hit_counter.sv
verif/tlb_replacement_hit_counter_tb.sv
